FILE: src/lsdt_pkg.sv
// shared constants, types and helpers for the lru stack depth tracker
`default_nettype none
package lsdt_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int PAGE_BITS   = 20;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // fixed port field widths
  localparam int PAGE_NUM_W  = 20;
  localparam int CAP_W       = 7;
  localparam int DEPTH_W     = 6;
  localparam int DEPTH_MAX   = 63;

  typedef logic [PAGE_BITS-1:0] page_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    logic valid;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_SHIFT
  } seq_state_t;

  // clamp a stack position to the depth field range
  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [IDX_W-1:0] idx);
    logic [DEPTH_W-1:0] res;
    if (32'(idx) > 32'(DEPTH_MAX)) begin
      res = DEPTH_W'(DEPTH_MAX);
    end else begin
      res = DEPTH_W'(idx);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: src/lsdt_cell.sv
// one stack position: holds a page, compares it with the key, shifts from its neighbor
`default_nettype none
module lsdt_cell
  import lsdt_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire page_t     key,
  input  wire page_t     prev_entry,
  output page_t          entry,
  output logic           match
);

  page_t entry_r;
  logic  match_r;

  // entry storage, takes the upper neighbor's page on a shift
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      entry_r <= prev_entry;
    end
  end

  // registered compare against the reference key
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= ctl.valid && (entry_r == key);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

FILE: src/lru_stack_depth_tracker_unit.sv
// top level: lru stack distance tracker built from a row of compare-and-shift cells
//
// Usage:
//   Input: drive in_page_number and pulse start while busy is low; the beat
//   is taken at that clock edge. busy stays high until the result is out.
//   Result: out_valid is high for exactly one cycle with out_hit and
//   out_stack_depth; the receiver cannot stall, so it must take the beat.
//   out_stack_depth is the position from the most recently used end on a
//   hit (0 for the top) and 0 on a miss.
//   Config: cfg_capacity_in_use is written when cfg_valid and cfg_ready are
//   both high; cfg_ready is always high. Write it only while idle.
//   Sequence: an item passes through compare, encode and shift in turn;
//   busy drops with the result strobe, so a new item is accepted only once
//   the last one is through. The three steps over the cell row: register
//   the per-cell matches, encode the hit position, shift the row.
//   Reset: synchronous, active low; the stack comes up empty and the
//   capacity comes up at 64. Stack contents need no clearing.
`default_nettype none
module lru_stack_depth_tracker_unit
  import lsdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PAGE_NUM_W-1:0] in_page_number,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [DEPTH_W-1:0]         out_stack_depth,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CAP_W-1:0]      cfg_capacity_in_use
);

  seq_state_t          state_r, state_nxt;
  page_t               page_r;
  logic [CAP_W-1:0]    capacity_r;
  logic [CNT_W-1:0]    count_r, count_nxt, upd_count_r;
  logic [IDX_W-1:0]    limit_r, limit_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic                out_valid_r, out_hit_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic                accept;
  logic                cmp_phase, shift_phase, enc_phase;
  logic [CNT_W-1:0]    cap_eff, keep;

  cell_ctl_t           ctl   [STACK_DEPTH];
  page_t               entry [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] match;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and phase strobes
  always_comb begin
    state_nxt   = state_r;
    cmp_phase   = 1'b0;
    enc_phase   = 1'b0;
    shift_phase = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmp_phase = 1'b1;
        state_nxt = ST_ENC;
      end
      ST_ENC: begin
        enc_phase = 1'b1;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        shift_phase = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= PAGE_BITS'(in_page_number);
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity_in_use;
    end
  end

  // effective capacity clamped to one and the stack depth
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity_r) > 32'(STACK_DEPTH)) begin
      cap_eff = CNT_W'(STACK_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
    keep = (count_r > (cap_eff - CNT_W'(1))) ? (cap_eff - CNT_W'(1)) : count_r;
  end

  // one-hot match vector to position
  always_comb begin
    hit_idx_nxt = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (match[i]) begin
        hit_idx_nxt = hit_idx_nxt | IDX_W'(i);
      end
    end
    hit_nxt = |match;
  end

  // shift limit and new fill count
  always_comb begin
    if (hit_nxt) begin
      limit_nxt = hit_idx_nxt;
      count_nxt = count_r;
    end else begin
      limit_nxt = IDX_W'(keep);
      count_nxt = keep + CNT_W'(1);
    end
  end

  // encode stage registers
  always_ff @(posedge clk) begin
    if (enc_phase) begin
      hit_r       <= hit_nxt;
      hit_idx_r   <= hit_idx_nxt;
      limit_r     <= limit_nxt;
      upd_count_r <= count_nxt;
    end
  end

  // fill count of valid entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (shift_phase) begin
      count_r <= upd_count_r;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= shift_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_phase) begin
      out_hit_r   <= hit_r;
      out_depth_r <= hit_r ? sat_depth(hit_idx_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_stack_depth = out_depth_r;

  // row of stack cells, top at position 0
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    page_t prev;

    assign ctl[g].cmp_en   = cmp_phase;
    assign ctl[g].shift_en = shift_phase && (IDX_W'(g) <= limit_r);
    assign ctl[g].valid    = (CNT_W'(g) < count_r);

    if (g == 0) begin : g_top
      assign prev = page_r;
    end else begin : g_rest
      assign prev = entry[g-1];
    end

    lsdt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .key        (page_r),
      .prev_entry (prev),
      .entry      (entry[g]),
      .match      (match[g])
    );
  end

endmodule
`default_nettype wire

FILE: tb/tb_lru_stack_depth_tracker_unit.sv
// testbench for the lru stack depth tracker: directed table, then random page traces
`timescale 1ns / 1ps
module tb_lru_stack_depth_tracker_unit;
  import lsdt_pkg::*;

  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 82;
  localparam int DIR_ROWS        = 25;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT  = 1000;

  typedef logic [PAGE_NUM_W-1:0] ref_page_t;

  // one directed reference: capacity to hold, page, and an optional typed-in answer
  typedef struct packed {
    logic [CAP_W-1:0]   cap;
    ref_page_t          page;
    logic               typed;
    logic               hit;
    logic [DEPTH_W-1:0] depth;
  } dir_row_t;

  // one lookup waiting for its answer
  typedef struct packed {
    ref_page_t          page;
    logic               hit;
    logic [DEPTH_W-1:0] depth;
  } lookup_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [PAGE_NUM_W-1:0] in_page_number;
  logic                  out_valid;
  logic                  out_hit;
  logic [DEPTH_W-1:0]    out_stack_depth;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_capacity_in_use;

  // answer typed into the directed table for the beat being offered
  logic                  typed_valid;
  logic                  typed_hit;
  logic [DEPTH_W-1:0]    typed_depth;

  // model of the stack, top first
  ref_page_t             tracked_pages [STACK_DEPTH];
  int unsigned           tracked_count;
  logic [CAP_W-1:0]      frame_limit;

  lookup_result_t        pending_lookups [$];

  int unsigned           error_count;
  int unsigned           refs_issued;
  int unsigned           hits_seen;
  int unsigned           misses_seen;
  int unsigned           deepest_hit;
  int unsigned           capacity_writes;
  int unsigned           stall_cycles;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // after reset, field extremes, hits at the top and further down
    '{7'd64,  20'h00000, 1'b1, 1'b0, 6'd0},
    '{7'd64,  20'hFFFFF, 1'b1, 1'b0, 6'd0},
    '{7'd64,  20'hFFFFF, 1'b1, 1'b1, 6'd0},
    '{7'd64,  20'h00000, 1'b1, 1'b1, 6'd1},
    '{7'd64,  20'hAAAAA, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'h55555, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'h00000, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'hFFFFF, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'h00001, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'h80000, 1'b0, 1'b0, 6'd0},
    // capacity lowered below the entry count: deep hit still found, miss truncates
    '{7'd2,   20'hAAAAA, 1'b1, 1'b1, 6'd5},
    '{7'd2,   20'h12345, 1'b1, 1'b0, 6'd0},
    '{7'd2,   20'h80000, 1'b0, 1'b0, 6'd0},
    '{7'd2,   20'h12345, 1'b0, 1'b0, 6'd0},
    // zero capacity acts as a single frame
    '{7'd0,   20'h00000, 1'b1, 1'b0, 6'd0},
    '{7'd0,   20'h00000, 1'b1, 1'b1, 6'd0},
    '{7'd0,   20'hFFFFF, 1'b1, 1'b0, 6'd0},
    '{7'd0,   20'h00000, 1'b1, 1'b0, 6'd0},
    // capacity above the stack depth saturates
    '{7'd127, 20'h0F0F0, 1'b0, 1'b0, 6'd0},
    '{7'd127, 20'h00000, 1'b0, 1'b0, 6'd0},
    // single frame with two entries still held
    '{7'd1,   20'h00000, 1'b1, 1'b1, 6'd0},
    '{7'd1,   20'h0F0F0, 1'b1, 1'b1, 6'd1},
    '{7'd1,   20'h00F0F, 1'b1, 1'b0, 6'd0},
    '{7'd64,  20'h0F0F0, 1'b0, 1'b0, 6'd0},
    '{7'd64,  20'h00F0F, 1'b0, 1'b0, 6'd0}
  };

  logic [CAP_W-1:0] phase_caps [NUM_PHASES] = '{
    7'd64, 7'd127, 7'd96, 7'd17, 7'd1, 7'd64, 7'd65,
    7'd0,  7'd2,   7'd64, 7'd33, 7'd100, 7'd5, 7'd64
  };

  lru_stack_depth_tracker_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_page_number      (in_page_number),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_stack_depth     (out_stack_depth),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // search the stack, move the page to the top, evict on a full miss
  task automatic lookup_and_promote(input ref_page_t pg, output logic found,
                                    output logic [DEPTH_W-1:0] pos);
    int unsigned d;
    int unsigned keep;
    int unsigned cap;
    int unsigned hit_at;
    bit          matched;
    matched = 1'b0;
    hit_at  = 0;
    for (d = 0; d < tracked_count; d++) begin
      if (!matched && tracked_pages[d] == pg) begin
        matched = 1'b1;
        hit_at  = d;
      end
    end
    if (matched) begin
      keep = hit_at;
    end else begin
      cap = frame_limit;
      if (cap < 1) cap = 1;
      if (cap > STACK_DEPTH) cap = STACK_DEPTH;
      keep = tracked_count;
      if (keep > cap - 1) keep = cap - 1;
      tracked_count = keep + 1;
    end
    for (d = keep; d > 0; d--) begin
      tracked_pages[d] = tracked_pages[d-1];
    end
    tracked_pages[0] = pg;
    found = matched;
    if (!matched) begin
      pos = '0;
    end else if (hit_at > DEPTH_MAX) begin
      pos = DEPTH_W'(DEPTH_MAX);
    end else begin
      pos = DEPTH_W'(hit_at);
    end
  endtask

  // result check, config tracking and prediction, all at the rising edge
  always @(posedge clk) begin
    lookup_result_t     due;
    logic               p_hit;
    logic [DEPTH_W-1:0] p_depth;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_lookups.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected: hit %0d depth %0d",
                   $time, out_hit, out_stack_depth);
        end else begin
          due = pending_lookups.pop_front();
          if (out_hit !== due.hit) begin
            error_count++;
            $display("%0t: page %h hit expected %0d actual %0d",
                     $time, due.page, due.hit, out_hit);
          end
          if (out_stack_depth !== due.depth) begin
            error_count++;
            $display("%0t: page %h stack_depth expected %0d actual %0d",
                     $time, due.page, due.depth, out_stack_depth);
          end
          if (due.hit) begin
            hits_seen++;
            if (due.depth > deepest_hit) deepest_hit = due.depth;
          end else begin
            misses_seen++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        frame_limit = cfg_capacity_in_use;
        capacity_writes++;
      end
      if (start && !busy) begin
        lookup_and_promote(in_page_number, p_hit, p_depth);
        if (typed_valid) begin
          p_hit   = typed_hit;
          p_depth = typed_depth;
        end
        pending_lookups.push_back('{in_page_number, p_hit, p_depth});
        refs_issued++;
      end
    end
  end

  // watchdog on cycles where no beat moves anywhere
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("tb_lru_stack_depth_tracker_unit failed");
      $finish;
    end
  end

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random page: hits at any depth, the bottom entry, a small pool, or anything
  function automatic ref_page_t pick_reference_page();
    int unsigned mode;
    ref_page_t   pg;
    mode = $urandom_range(0, 99);
    if (tracked_count != 0 && mode < 30) begin
      pg = tracked_pages[$urandom_range(0, tracked_count - 1)];
    end else if (tracked_count != 0 && mode < 45) begin
      pg = tracked_pages[tracked_count - 1];
    end else if (mode < 65) begin
      pg = ref_page_t'($urandom_range(0, 31));
    end else begin
      pg = ref_page_t'($urandom);
    end
    return pg;
  endfunction

  // offer one reference beat after a gap, return once it is taken
  task automatic issue_reference(input ref_page_t pg, input int unsigned gap,
                                 input logic tv, input logic th,
                                 input logic [DEPTH_W-1:0] td);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_page_number <= pg;
    typed_valid    <= tv;
    typed_hit      <= th;
    typed_depth    <= td;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait for every answer to come back
  task automatic settle_pipeline();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_lookups.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write the capacity register while the block is idle
  task automatic apply_capacity(input logic [CAP_W-1:0] cap);
    settle_pipeline();
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_capacity_in_use <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [CAP_W-1:0] cur_cap;
    int unsigned      gap;
    bit               no_gaps;
    start               = 1'b0;
    in_page_number      = '0;
    cfg_valid           = 1'b0;
    cfg_capacity_in_use = '0;
    typed_valid         = 1'b0;
    typed_hit           = 1'b0;
    typed_depth         = '0;
    tracked_count       = 0;
    frame_limit         = CAP_W'(STACK_DEPTH);
    error_count         = 0;
    refs_issued         = 0;
    hits_seen           = 0;
    misses_seen         = 0;
    deepest_hit         = 0;
    capacity_writes     = 0;
    stall_cycles        = 0;
    for (int i = 0; i < STACK_DEPTH; i++) tracked_pages[i] = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    cur_cap = CAP_W'(STACK_DEPTH);
    apply_capacity(cur_cap);
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].cap != cur_cap) begin
        cur_cap = dir_rows[r].cap;
        apply_capacity(cur_cap);
      end
      issue_reference(dir_rows[r].page, next_gap(), dir_rows[r].typed,
                      dir_rows[r].hit, dir_rows[r].depth);
    end

    // random traces, one capacity per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_capacity(phase_caps[p]);
      no_gaps = (p % 4 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) settle_pipeline();
        gap = no_gaps ? 0 : next_gap();
        issue_reference(pick_reference_page(), gap, 1'b0, 1'b0, '0);
      end
    end

    settle_pipeline();
    repeat (10) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      error_count++;
      $display("%0t: %0d lookups never answered", $time, pending_lookups.size());
    end
    $display("covered %0d references (%0d hits, %0d misses), deepest hit at %0d",
             refs_issued, hits_seen, misses_seen, deepest_hit);
    $display("over %0d capacity settings, with %0d mismatches", capacity_writes, error_count);
    if (error_count == 0) begin
      $display("tb_lru_stack_depth_tracker_unit passed");
    end else begin
      $display("tb_lru_stack_depth_tracker_unit failed");
    end
    $finish;
  end

endmodule
